### sv/qsed_pkg.sv
// Shared types, codes and helpers for the quoted string escape decoder.
package qsed_pkg;

    localparam int MAX_DECODED_DEF = 4095;
    localparam int LEN_W           = 12;

    // decode modes
    localparam logic [2:0] MODE_OPEN   = 3'd0;
    localparam logic [2:0] MODE_BODY   = 3'd1;
    localparam logic [2:0] MODE_ESC    = 3'd2;
    localparam logic [2:0] MODE_HEX_HI = 3'd3;
    localparam logic [2:0] MODE_HEX_LO = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_UNTERMINATED = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE   = 3'd2;
    localparam logic [2:0] ST_BAD_HEX      = 3'd3;
    localparam logic [2:0] ST_UNKNOWN      = 3'd4;
    localparam logic [2:0] ST_NO_OPEN      = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] VAL_LF    = 8'd10;
    localparam logic [7:0] VAL_CR    = 8'd13;
    localparam logic [7:0] VAL_TAB   = 8'd9;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] nibble;
        logic [2:0] err;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] obyte;
        logic       ovalid;
        logic       done;
        logic [2:0] status;
    } dec_res_t;

    // {ok, value} for one hex digit of either case
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

### sv/qsed_step.sv
// Next-state and result logic for one text byte.
module qsed_step #(
    parameter int MAX_DECODED = qsed_pkg::MAX_DECODED_DEF,
    parameter int CW          = $clog2(MAX_DECODED + 1)
) (
    input  qsed_pkg::dec_state_t cur,
    input  logic [CW-1:0]        cnt,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output qsed_pkg::dec_state_t nxt,
    output logic [CW-1:0]        cnt_next,
    output logic [CW-1:0]        cnt_report,
    output qsed_pkg::dec_res_t   res
);
    import qsed_pkg::*;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_DECODED);

    logic [4:0] hx;
    logic [2:0] st;

    assign hx = hex_digit(in_byte);

    always_comb
    begin
        nxt      = cur;
        cnt_next = cnt;
        st       = ST_OK;
        res      = '0;
        if (in_last)
        begin
            if (cur.mode == MODE_OPEN)
                st = (in_byte == CH_QUOTE) ? ST_UNTERMINATED : ST_NO_OPEN;
            else if (cur.err == ST_NO_OPEN)
                st = ST_NO_OPEN;
            else if (in_byte != CH_QUOTE)
                st = ST_UNTERMINATED;
            else if (cur.err != ST_OK)
                st = cur.err;
            else if (cur.mode == MODE_ESC)
                st = ST_INCOMPLETE;
            else if (cur.mode == MODE_HEX_HI || cur.mode == MODE_HEX_LO)
                st = ST_BAD_HEX;
            else
                st = ST_OK;
            res.done   = 1'b1;
            res.status = st;
            nxt.mode   = MODE_OPEN;
            nxt.nibble = 4'd0;
            nxt.err    = ST_OK;
            cnt_next   = '0;
        end
        else
        begin
            if (cur.mode == MODE_OPEN)
            begin
                if (in_byte != CH_QUOTE)
                    nxt.err = ST_NO_OPEN;
                nxt.mode = MODE_BODY;
            end
            else if (cur.err == ST_OK)
            begin
                case (cur.mode)
                    MODE_ESC:
                    begin
                        nxt.mode = MODE_BODY;
                        if (in_byte == CH_QUOTE || in_byte == CH_BSLASH)
                        begin
                            res.obyte  = in_byte;
                            res.ovalid = 1'b1;
                        end
                        else if (in_byte == CH_N)
                        begin
                            res.obyte  = VAL_LF;
                            res.ovalid = 1'b1;
                        end
                        else if (in_byte == CH_R)
                        begin
                            res.obyte  = VAL_CR;
                            res.ovalid = 1'b1;
                        end
                        else if (in_byte == CH_T)
                        begin
                            res.obyte  = VAL_TAB;
                            res.ovalid = 1'b1;
                        end
                        else if (in_byte == CH_X)
                            nxt.mode = MODE_HEX_HI;
                        else
                            nxt.err = ST_UNKNOWN;
                    end
                    MODE_HEX_HI:
                    begin
                        if (!hx[4])
                            nxt.err = ST_BAD_HEX;
                        else
                        begin
                            nxt.nibble = hx[3:0];
                            nxt.mode   = MODE_HEX_LO;
                        end
                    end
                    MODE_HEX_LO:
                    begin
                        if (!hx[4])
                            nxt.err = ST_BAD_HEX;
                        else
                        begin
                            res.obyte  = {cur.nibble, hx[3:0]};
                            res.ovalid = 1'b1;
                            nxt.mode   = MODE_BODY;
                        end
                    end
                    default:
                    begin
                        if (in_byte == CH_BSLASH)
                            nxt.mode = MODE_ESC;
                        else
                        begin
                            res.obyte  = in_byte;
                            res.ovalid = 1'b1;
                        end
                    end
                endcase
                if (res.ovalid && cnt < MAX_C)
                    cnt_next = cnt + CW'(1);
            end
            res.status = nxt.err;
        end
    end

    // the final word reports the count it found; others report the updated one
    assign cnt_report = in_last ? cnt : cnt_next;

endmodule

### sv/quoted_string_escape_decoder_top.sv
// Top level of the quoted string escape decoder: decode state, result register and skid.
// Takes a quoted text one byte word per cycle and returns one registered result word per
// input word. Throughput is one word per clock while in_ready is high; the only loop is
// the update of the decode state (mode, pending hex nibble, first error, count).
// A two-entry output stage (result register plus skid register) lets input keep flowing
// while a result waits, and holds in_ready low only when both entries are full.
module quoted_string_escape_decoder_top #(
    parameter int MAX_DECODED = qsed_pkg::MAX_DECODED_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       done_res,
    output logic [2:0] status,
    output logic [11:0] decoded_length
);
    import qsed_pkg::*;

    localparam int CW = $clog2(MAX_DECODED + 1);

    typedef struct packed {
        dec_res_t         r;
        logic [LEN_W-1:0] len;
    } word_t;

    dec_state_t       st_reg, st_next;
    logic [CW-1:0]    cnt_reg, cnt_next, cnt_report;
    dec_res_t         step_res;
    logic [CW+LEN_W-1:0] cnt_ext;
    word_t            new_word;

    word_t            out_reg, skid_reg;
    logic             out_vld_reg, skid_vld_reg;
    logic             in_fire, out_fire;

    qsed_step #(
        .MAX_DECODED (MAX_DECODED),
        .CW          (CW)
    ) u_step (
        .cur        (st_reg),
        .cnt        (cnt_reg),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .nxt        (st_next),
        .cnt_next   (cnt_next),
        .cnt_report (cnt_report),
        .res        (step_res)
    );

    // length is the count modulo 2^12
    assign cnt_ext      = {{LEN_W{1'b0}}, cnt_report};
    assign new_word.r   = step_res;
    assign new_word.len = cnt_ext[LEN_W-1:0];

    assign in_ready = !skid_vld_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_vld_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '{mode: MODE_OPEN, nibble: 4'd0, err: ST_OK};
            cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!out_vld_reg || out_fire)
            begin
                out_vld_reg  <= skid_vld_reg || in_fire;
                skid_vld_reg <= 1'b0;
            end
            else if (in_fire)
                skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || out_fire)
        begin
            if (skid_vld_reg)
                out_reg <= skid_reg;
            else if (in_fire)
                out_reg <= new_word;
        end
        else if (in_fire)
            skid_reg <= new_word;
    end

    assign res_valid      = out_vld_reg;
    assign out_byte       = out_reg.r.obyte;
    assign out_valid      = out_reg.r.ovalid;
    assign done_res       = out_reg.r.done;
    assign status         = out_reg.r.status;
    assign decoded_length = out_reg.len;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid word held with empty result register");

    a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.r.done) |-> !out_reg.r.ovalid)
        else $error("final word carries a decoded byte");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=> (st_reg.mode == MODE_OPEN && st_reg.err == ST_OK
                                  && cnt_reg == '0))
        else $error("decode state not cleared after final word");

    a_no_emit_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && st_reg.err != ST_OK) |-> !step_res.ovalid)
        else $error("byte emitted after an error");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_DECODED))
        else $error("decoded count beyond its limit");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the quoted string escape decoder.
module tb_top;
    import qsed_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_CYCLES = 64;

    typedef struct packed {
        logic [7:0]  obyte;
        logic        ovalid;
        logic        done;
        logic [2:0]  st;
        logic [11:0] len;
    } decoded_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'd0;
    logic        in_last = 1'b0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [11:0] decoded_length;

    // predictor state
    logic [2:0] pm_mode = MODE_OPEN;
    logic [3:0] pm_nibble = 4'd0;
    logic [2:0] pm_err = ST_OK;
    int         pm_count = 0;

    decoded_word_t pending_results[$];
    int  words_sent = 0;
    int  fails = 0;
    int  idle_cycles = 0;
    int  max_gap = 9;
    int  max_stall = 9;
    bit  hold_req = 1'b0;

    quoted_string_escape_decoder_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .in_last        (in_last),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .out_byte       (out_byte),
        .out_valid      (out_valid),
        .done_res       (done_res),
        .status         (status),
        .decoded_length (decoded_length)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // {ok, nibble}; case folding via bit 5 covers both letter ranges
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, c[3:0]};
        if (lc >= 8'h61 && lc <= 8'h66)
            return {1'b1, 4'(c[3:0] + 4'd9)};
        return 5'd0;
    endfunction

    function automatic decoded_word_t decode_word(input logic [7:0] b, input logic l);
        decoded_word_t r;
        logic [4:0]    h;
        r = '0;
        if (l)
        begin
            if (pm_mode == MODE_OPEN)
                r.st = (b == CH_QUOTE) ? ST_UNTERMINATED : ST_NO_OPEN;
            else if (pm_err == ST_NO_OPEN)
                r.st = ST_NO_OPEN;
            else if (b != CH_QUOTE)
                r.st = ST_UNTERMINATED;
            else if (pm_err != ST_OK)
                r.st = pm_err;
            else if (pm_mode == MODE_ESC)
                r.st = ST_INCOMPLETE;
            else if (pm_mode == MODE_HEX_HI || pm_mode == MODE_HEX_LO)
                r.st = ST_BAD_HEX;
            else
                r.st = ST_OK;
            r.done = 1'b1;
            r.len = pm_count[11:0];
            pm_mode = MODE_OPEN;
            pm_nibble = 4'd0;
            pm_err = ST_OK;
            pm_count = 0;
            return r;
        end
        if (pm_mode == MODE_OPEN)
        begin
            if (b != CH_QUOTE)
                pm_err = ST_NO_OPEN;
            pm_mode = MODE_BODY;
        end
        else if (pm_err == ST_OK)
        begin
            case (pm_mode)
                MODE_ESC:
                begin
                    pm_mode = MODE_BODY;
                    if (b == CH_QUOTE || b == CH_BSLASH)
                        r.obyte = b;
                    else if (b == CH_N)
                        r.obyte = VAL_LF;
                    else if (b == CH_R)
                        r.obyte = VAL_CR;
                    else if (b == CH_T)
                        r.obyte = VAL_TAB;
                    else if (b == CH_X)
                        pm_mode = MODE_HEX_HI;
                    else
                        pm_err = ST_UNKNOWN;
                    r.ovalid = (pm_mode == MODE_BODY && pm_err == ST_OK);
                end
                MODE_HEX_HI:
                begin
                    h = nibble_of(b);
                    if (!h[4])
                        pm_err = ST_BAD_HEX;
                    else
                    begin
                        pm_nibble = h[3:0];
                        pm_mode = MODE_HEX_LO;
                    end
                end
                MODE_HEX_LO:
                begin
                    h = nibble_of(b);
                    if (!h[4])
                        pm_err = ST_BAD_HEX;
                    else
                    begin
                        r.obyte = {pm_nibble, h[3:0]};
                        r.ovalid = 1'b1;
                        pm_mode = MODE_BODY;
                    end
                end
                default:
                begin
                    if (b == CH_BSLASH)
                        pm_mode = MODE_ESC;
                    else
                    begin
                        r.obyte = b;
                        r.ovalid = 1'b1;
                    end
                end
            endcase
            if (r.ovalid && pm_count < MAX_DECODED_DEF)
                pm_count++;
        end
        r.st = pm_err;
        r.len = pm_count[11:0];
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= l;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(decode_word(b, l));
        words_sent++;
    endtask

    task automatic send_text(input logic [7:0] txt[$]);
        foreach (txt[i])
            send_word(txt[i], i == txt.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_escapes();
        send_text('{CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH, CH_N,
                    CH_BSLASH, CH_R, CH_BSLASH, CH_T, CH_BSLASH, CH_X, 8'h61, 8'h46,
                    CH_QUOTE});
        wait_drained();
    endtask

    task automatic test_status_codes();
        send_text('{CH_QUOTE});                            // single quote only
        send_text('{8'hFF});                               // no opening quote
        send_text('{CH_QUOTE, CH_BSLASH, CH_QUOTE});       // lone backslash at end
        send_text('{CH_QUOTE, CH_BSLASH, CH_X, CH_QUOTE}); // hex escape left open
        send_text('{CH_QUOTE, CH_BSLASH, 8'h71, 8'h61, CH_QUOTE}); // unknown, then muted
        send_text('{8'h27, CH_QUOTE, CH_QUOTE});           // no open beats later bytes
        wait_drained();
    endtask

    task automatic test_raw_bytes();
        // extremes, quote in the body, final byte not a quote
        send_text('{CH_QUOTE, 8'h00, 8'hFF, CH_QUOTE, 8'h01});
        send_text('{CH_QUOTE, CH_BSLASH, CH_X, 8'h39, 8'h30, CH_QUOTE});
        wait_drained();
    endtask

    task automatic test_long_text();
        logic [7:0] txt[$];
        logic [7:0] c;
        max_gap = 0;
        max_stall = 0;
        txt.push_back(CH_QUOTE);
        repeat (100)
        begin
            c = 8'($urandom_range(0, 255));
            txt.push_back(c == CH_BSLASH ? 8'h5D : c);
        end
        txt.push_back(CH_QUOTE);
        send_text(txt);
        wait_drained();
        max_gap = 9;
        max_stall = 9;
    endtask

    task automatic test_backpressure();
        logic [7:0] txt[$];
        max_gap = 0;
        hold_req = 1'b1;
        txt.push_back(CH_QUOTE);
        repeat (30)
            txt.push_back(8'($urandom_range(8'h20, 8'h7E)) & 8'h7B);
        txt.push_back(CH_QUOTE);
        send_text(txt);
        wait_drained();
        max_gap = 9;
    endtask

    task automatic test_random();
        logic [7:0] txt[$];
        logic [7:0] c;
        int         start;
        int         kind;
        int         ntok;
        start = words_sent;
        while (words_sent - start < 560)
        begin
            txt.delete();
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 9;
            max_stall = ($urandom_range(0, 3) == 0) ? 0 : 9;
            kind = $urandom_range(0, 9);
            if (kind <= 7)
            begin
                txt.push_back(CH_QUOTE);
                ntok = $urandom_range(0, 10);
                repeat (ntok)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3:
                        begin
                            c = 8'($urandom_range(0, 255));
                            txt.push_back(c == CH_BSLASH ? 8'h41 : c);
                        end
                        4:
                        begin
                            txt.push_back(CH_BSLASH);
                            txt.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
                        end
                        5:
                        begin
                            txt.push_back(CH_BSLASH);
                            case ($urandom_range(0, 2))
                                0: txt.push_back(CH_N);
                                1: txt.push_back(CH_R);
                                default: txt.push_back(CH_T);
                            endcase
                        end
                        6, 7:
                        begin
                            txt.push_back(CH_BSLASH);
                            txt.push_back(CH_X);
                            txt.push_back(hex_char(4'($urandom_range(0, 15))));
                            txt.push_back(hex_char(4'($urandom_range(0, 15))));
                        end
                        8:
                        begin
                            txt.push_back(CH_BSLASH);
                            txt.push_back(8'($urandom_range(0, 255)));
                        end
                        default:
                        begin
                            // hex escape with arbitrary digits, mostly bad
                            txt.push_back(CH_BSLASH);
                            txt.push_back(CH_X);
                            txt.push_back(8'($urandom_range(0, 255)));
                            txt.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end
                if (kind == 7)
                begin
                    // escape still open when the text ends
                    txt.push_back(CH_BSLASH);
                    if ($urandom_range(0, 2) != 0)
                        txt.push_back(CH_X);
                    if ($urandom_range(0, 1) != 0)
                        txt.push_back(hex_char(4'($urandom_range(0, 15))));
                end
                txt.push_back(($urandom_range(0, 9) != 0) ? CH_QUOTE
                                                          : 8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 6))
                    txt.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) != 0)
                    txt[0] = CH_QUOTE;
            end
            else
            begin
                if ($urandom_range(0, 1) != 0)
                    txt.push_back(CH_QUOTE);
                txt.push_back($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
            end
            send_text(txt);
        end
        wait_drained();
        max_gap = 9;
        max_stall = 9;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_escapes();
        test_status_codes();
        test_raw_bytes();
        test_backpressure();
        test_long_text();
        test_random();
        wait_drained();
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = $urandom_range(0, max_stall);
                if (stall > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        decoded_word_t e;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, byte %0h status %0d", $time,
                         out_byte, status);
                fails++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_byte !== e.obyte)
                begin
                    $display("%0t: out_byte expected %0h actual %0h", $time, e.obyte, out_byte);
                    fails++;
                end
                if (out_valid !== e.ovalid)
                begin
                    $display("%0t: out_valid expected %0b actual %0b", $time, e.ovalid,
                             out_valid);
                    fails++;
                end
                if (done_res !== e.done)
                begin
                    $display("%0t: done_res expected %0b actual %0b", $time, e.done, done_res);
                    fails++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    fails++;
                end
                if (decoded_length !== e.len)
                begin
                    $display("%0t: decoded_length expected %0d actual %0d", $time, e.len,
                             decoded_length);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule

### sim.f
sv/qsed_pkg.sv
sv/qsed_step.sv
sv/quoted_string_escape_decoder_top.sv
tb/tb_top.sv
